// ----- rtl/core/gtr_pkg.sv -----
// shared types and constants for the greedy text reflow unit
// no dependencies; used by gtr_ctrl, gtr_dpath and greedy_text_reflow_unit
`default_nettype none

package gtr_pkg;

   localparam int         MAX_WIDTH_DEF  = 128;
   localparam logic [7:0] LINE_WIDTH_RST = 8'd75;
   localparam logic [3:0] CHUNK_BYTES    = 4'd8;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAD,
      ST_HELD,
      ST_TAIL1,
      ST_TAIL2
   } state_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_EOS,
      ACT_NL,
      ACT_WHITE,
      ACT_FIRST,
      ACT_PASS,
      ACT_HOLD,
      ACT_BREAK
   } action_type;

   typedef enum logic [1:0] {
      SRC_SPACE,
      SRC_NL,
      SRC_ITEM,
      SRC_MEM
   } src_type;

   typedef struct packed {
      logic       accept;
      action_type act;
      logic       push;
      src_type    src;
      logic       last_beat;
      logic       rd;
      logic       rd_restart;
   } cmd_type;

   typedef struct packed {
      logic in_eos;
      logic in_nl;
      logic in_white;
      logic col_zero;
      logic word_open;
      logic placed;
      logic para_open;
      logic line_word;
      logic overflow;
      logic held_last;
      logic pack_ready;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/core/greedy_text_reflow_unit.sv -----
// top level of the greedy text reflow unit: ties controller and datapath
// to the stream and csr ports; depends on gtr_pkg, gtr_ctrl, gtr_dpath
//
//   port group   dir   beat contents
//   req_*        in    tdata[7:0] in_byte, tlast end_of_stream
//   rsp_*        out   tdata[63:0] out_bytes, tdata[67:64] byte_count, tlast last_of_run
//   csr_*        in    csr_wr_data line_width, written when csr_wr_en is high
//
// a beat is taken only while the controller is idle; each output byte it
// causes then goes through the byte packer (lead byte, held word bytes from
// the word store read port, trailing newlines), waiting while rsp_tready is low.
// a beat that causes no bytes returns to idle at once; the last chunk
// is first closed in the accumulator and then moves to the output register.
// reset is synchronous; the word store needs no clearing pass.
`default_nettype none

module greedy_text_reflow_unit #(
   parameter int MAX_WIDTH = gtr_pkg::MAX_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] in_byte
   input  wire logic        req_tlast,   // end_of_stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // [63:0] out_bytes, [67:64] byte_count
   output logic             rsp_tlast,   // last_of_run
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data  // line_width
);

   gtr_pkg::cmd_type    cmd;
   gtr_pkg::status_type stat;
   logic [63:0]         out_bytes;
   logic [3:0]          out_count;

   gtr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   gtr_dpath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_byte     (req_tdata),
      .in_eos      (req_tlast),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .out_bytes   (out_bytes),
      .out_count   (out_count),
      .out_last    (rsp_tlast),
      .cmd         (cmd),
      .stat        (stat)
   );

   assign rsp_tdata = {4'b0000, out_count, out_bytes};

endmodule

`default_nettype wire

// ----- rtl/core/gtr_ctrl.sv -----
// controller for the greedy text reflow unit: classifies each beat and
// sequences the output bytes; depends on gtr_pkg
`default_nettype none

module gtr_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire gtr_pkg::status_type stat,
   output gtr_pkg::cmd_type        cmd
);

   gtr_pkg::state_type state_ff, state_in;
   gtr_pkg::src_type   lead_ff, lead_in;
   logic               held_ff, held_in;
   logic               tail1_ff, tail1_in;
   logic               tail2_ff, tail2_in;

   gtr_pkg::action_type act;
   gtr_pkg::src_type    lead_src;
   gtr_pkg::state_type  after_t1, after_held, after_lead;
   logic                flush, p_lead, p_held, p_t1, p_t2;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gtr_pkg::ST_IDLE;
         lead_ff  <= gtr_pkg::SRC_SPACE;
         held_ff  <= 1'b0;
         tail1_ff <= 1'b0;
         tail2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lead_ff  <= lead_in;
         held_ff  <= held_in;
         tail1_ff <= tail1_in;
         tail2_ff <= tail2_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      lead_in    = lead_ff;
      held_in    = held_ff;
      tail1_in   = tail1_ff;
      tail2_in   = tail2_ff;
      cmd        = '0;
      req_tready = (state_ff == gtr_pkg::ST_IDLE);

      // classify the incoming beat against the current paragraph state
      flush    = stat.word_open && !stat.placed;
      act      = gtr_pkg::ACT_HOLD;
      lead_src = gtr_pkg::SRC_SPACE;
      p_lead   = 1'b0;
      p_held   = 1'b0;
      p_t1     = 1'b0;
      p_t2     = 1'b0;
      priority if (stat.in_eos) begin
         act    = gtr_pkg::ACT_EOS;
         p_lead = flush;
         p_held = flush;
         p_t1   = stat.para_open;
      end else if (stat.in_nl) begin
         act    = gtr_pkg::ACT_NL;
         p_lead = flush;
         p_held = flush;
         p_t1   = !stat.line_word && stat.para_open;
         p_t2   = !stat.line_word;
      end else if (stat.in_white) begin
         act    = gtr_pkg::ACT_WHITE;
         p_lead = flush;
         p_held = flush;
      end else if (!stat.word_open && stat.col_zero) begin
         act      = gtr_pkg::ACT_FIRST;
         p_lead   = 1'b1;
         lead_src = gtr_pkg::SRC_ITEM;
      end else if (stat.word_open && stat.placed) begin
         act      = gtr_pkg::ACT_PASS;
         p_lead   = 1'b1;
         lead_src = gtr_pkg::SRC_ITEM;
      end else if (stat.overflow) begin
         // held word no longer fits: newline, then the word
         act      = gtr_pkg::ACT_BREAK;
         p_lead   = 1'b1;
         p_held   = 1'b1;
         lead_src = gtr_pkg::SRC_NL;
      end else begin
         act = gtr_pkg::ACT_HOLD;
      end

      after_t1   = tail2_ff ? gtr_pkg::ST_TAIL2 : gtr_pkg::ST_IDLE;
      after_held = tail1_ff ? gtr_pkg::ST_TAIL1 : after_t1;
      after_lead = held_ff ? gtr_pkg::ST_HELD : after_held;

      unique case (state_ff)
         gtr_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               cmd.act    = act;
               lead_in    = lead_src;
               held_in    = p_held;
               tail1_in   = p_t1;
               tail2_in   = p_t2;
               if (p_lead) begin
                  state_in = gtr_pkg::ST_LEAD;
               end else if (p_t1) begin
                  state_in = gtr_pkg::ST_TAIL1;
               end else if (p_t2) begin
                  state_in = gtr_pkg::ST_TAIL2;
               end else begin
                  state_in = gtr_pkg::ST_IDLE;
               end
            end
         end
         gtr_pkg::ST_LEAD: begin
            if (stat.pack_ready) begin
               cmd.push       = 1'b1;
               cmd.src        = lead_ff;
               cmd.last_beat  = !held_ff && !tail1_ff && !tail2_ff;
               cmd.rd         = held_ff;
               cmd.rd_restart = held_ff;
               state_in       = after_lead;
            end
         end
         gtr_pkg::ST_HELD: begin
            // read data for this byte was fetched when the previous byte was pushed
            if (stat.pack_ready) begin
               cmd.push      = 1'b1;
               cmd.src       = gtr_pkg::SRC_MEM;
               cmd.last_beat = stat.held_last && !tail1_ff && !tail2_ff;
               cmd.rd        = !stat.held_last;
               state_in      = stat.held_last ? after_held : gtr_pkg::ST_HELD;
            end
         end
         gtr_pkg::ST_TAIL1: begin
            if (stat.pack_ready) begin
               cmd.push      = 1'b1;
               cmd.src       = gtr_pkg::SRC_NL;
               cmd.last_beat = !tail2_ff;
               state_in      = after_t1;
            end
         end
         gtr_pkg::ST_TAIL2: begin
            if (stat.pack_ready) begin
               cmd.push      = 1'b1;
               cmd.src       = gtr_pkg::SRC_NL;
               cmd.last_beat = 1'b1;
               state_in      = gtr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gtr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/gtr_dpath.sv -----
// datapath for the greedy text reflow unit: paragraph state, word store,
// byte packer and output register; depends on gtr_pkg
`default_nettype none

module gtr_dpath #(
   parameter int MAX_WIDTH = gtr_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [7:0]          csr_wr_data,
   input  wire logic [7:0]          in_byte,
   input  wire logic                in_eos,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output logic [63:0]              out_bytes,
   output logic [3:0]               out_count,
   output logic                     out_last,
   input  wire gtr_pkg::cmd_type    cmd,
   output gtr_pkg::status_type      stat
);

   localparam int         AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam logic [7:0] MAXW8 = 8'(MAX_WIDTH);

   logic [7:0] word_mem [MAX_WIDTH];
   logic [7:0] rd_data_ff;

   logic [7:0]      width_ff, width_in;
   logic [7:0]      held_ff, held_in;
   logic [7:0]      col_ff, col_in;
   logic            para_ff, para_in;
   logic            inside_ff, inside_in;
   logic            placed_ff, placed_in;
   logic            lhw_ff, lhw_in;
   logic [7:0]      item_ff, item_in;
   logic [7:0]      remain_ff, remain_in;
   logic [AW-1:0]   addr_ff, addr_in;
   logic [7:0][7:0] acc_ff, acc_in;
   logic [3:0]      cnt_ff, cnt_in;
   logic            fin_ff, fin_in;
   logic            out_valid_ff, out_valid_in;
   logic [63:0]     out_bytes_ff, out_bytes_in;
   logic [3:0]      out_count_ff, out_count_in;
   logic            out_last_ff, out_last_in;

   logic [7:0]    eff_w, new_held, end_col, col_inc, push_byte;
   logic [9:0]    fit_sum, end_sum;
   logic          flush, mem_wr, out_free, pack_ready;
   logic [AW-1:0] rd_addr;

   // word store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         word_mem[held_ff[AW-1:0]] <= in_byte;
      end
      if (cmd.rd) begin
         rd_data_ff <= word_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= gtr_pkg::LINE_WIDTH_RST;
         held_ff      <= '0;
         col_ff       <= '0;
         para_ff      <= 1'b0;
         inside_ff    <= 1'b0;
         placed_ff    <= 1'b0;
         lhw_ff       <= 1'b0;
         remain_ff    <= '0;
         addr_ff      <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         fin_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         held_ff      <= held_in;
         col_ff       <= col_in;
         para_ff      <= para_in;
         inside_ff    <= inside_in;
         placed_ff    <= placed_in;
         lhw_ff       <= lhw_in;
         remain_ff    <= remain_in;
         addr_ff      <= addr_in;
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         fin_ff       <= fin_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      out_bytes_ff <= out_bytes_in;
      out_count_ff <= out_count_in;
      out_last_ff  <= out_last_in;
   end

   // arithmetic on the paragraph state
   always_comb begin
      if (width_ff == 8'd0) begin
         eff_w = 8'd1;
      end else if (width_ff > MAXW8) begin
         eff_w = MAXW8;
      end else begin
         eff_w = width_ff;
      end
      new_held = (held_ff == 8'hFF) ? held_ff : held_ff + 8'd1;
      col_inc  = (col_ff == 8'hFF) ? col_ff : col_ff + 8'd1;
      fit_sum  = {2'b00, col_ff} + 10'd1 + {2'b00, new_held};
      end_sum  = {2'b00, col_ff} + 10'd1 + {2'b00, held_ff};
      end_col  = (end_sum > 10'd255) ? 8'hFF : end_sum[7:0];
      flush    = inside_ff && !placed_ff;
   end

   always_comb begin
      stat.in_eos     = in_eos;
      stat.in_nl      = (in_byte == gtr_pkg::CHAR_NL);
      stat.in_white   = (in_byte == gtr_pkg::CHAR_SPACE) ||
                        ((in_byte >= gtr_pkg::CHAR_TAB) && (in_byte <= gtr_pkg::CHAR_CR));
      stat.col_zero   = (col_ff == 8'd0);
      stat.word_open  = inside_ff;
      stat.placed     = placed_ff;
      stat.para_open  = para_ff;
      stat.line_word  = lhw_ff;
      stat.overflow   = (fit_sum > {2'b00, eff_w});
      stat.held_last  = (remain_ff == 8'd1);
      stat.pack_ready = pack_ready;
   end

   // state update on an accepted beat, a line width write or a pushed held byte
   always_comb begin
      width_in  = csr_wr_en ? csr_wr_data : width_ff;
      held_in   = held_ff;
      col_in    = col_ff;
      para_in   = para_ff;
      inside_in = inside_ff;
      placed_in = placed_ff;
      lhw_in    = lhw_ff;
      item_in   = item_ff;
      remain_in = remain_ff;
      mem_wr    = 1'b0;

      if (cmd.accept) begin
         item_in = in_byte;
         unique case (cmd.act)
            gtr_pkg::ACT_EOS: begin
               remain_in = held_ff;
               held_in   = '0;
               inside_in = 1'b0;
               placed_in = 1'b0;
               col_in    = '0;
               para_in   = 1'b0;
               lhw_in    = 1'b0;
            end
            gtr_pkg::ACT_NL: begin
               remain_in = held_ff;
               if (flush) begin
                  col_in = end_col;
               end
               held_in   = '0;
               inside_in = 1'b0;
               placed_in = 1'b0;
               // empty input line closes the paragraph
               if (!lhw_ff) begin
                  para_in = 1'b0;
                  col_in  = '0;
               end
               lhw_in = 1'b0;
            end
            gtr_pkg::ACT_WHITE: begin
               remain_in = held_ff;
               if (flush) begin
                  col_in = end_col;
               end
               held_in   = '0;
               inside_in = 1'b0;
               placed_in = 1'b0;
            end
            gtr_pkg::ACT_FIRST: begin
               inside_in = 1'b1;
               held_in   = '0;
               placed_in = 1'b1;
               para_in   = 1'b1;
               col_in    = 8'd1;
               lhw_in    = 1'b1;
            end
            gtr_pkg::ACT_PASS: begin
               col_in = col_inc;
               lhw_in = 1'b1;
            end
            gtr_pkg::ACT_HOLD: begin
               mem_wr    = 1'b1;
               held_in   = new_held;
               inside_in = 1'b1;
               placed_in = 1'b0;
               lhw_in    = 1'b1;
            end
            gtr_pkg::ACT_BREAK: begin
               mem_wr    = 1'b1;
               remain_in = new_held;
               col_in    = new_held;
               held_in   = '0;
               inside_in = 1'b1;
               placed_in = 1'b1;
               lhw_in    = 1'b1;
            end
            default: begin
               held_in = held_ff;
            end
         endcase
      end

      if (cmd.push && (cmd.src == gtr_pkg::SRC_MEM)) begin
         remain_in = remain_ff - 8'd1;
      end
   end

   // read address walks the held word from its first byte
   always_comb begin
      rd_addr = cmd.rd_restart ? '0 : addr_ff;
      addr_in = cmd.rd ? rd_addr + 1'b1 : addr_ff;
   end

   always_comb begin
      unique case (cmd.src)
         gtr_pkg::SRC_SPACE: push_byte = gtr_pkg::CHAR_SPACE;
         gtr_pkg::SRC_NL:    push_byte = gtr_pkg::CHAR_NL;
         gtr_pkg::SRC_ITEM:  push_byte = item_ff;
         gtr_pkg::SRC_MEM:   push_byte = rd_data_ff;
         default:            push_byte = rd_data_ff;
      endcase
   end

   // packer: a full chunk leaves only when another byte follows or the run ends
   always_comb begin
      out_free   = !out_valid_ff || rsp_tready;
      pack_ready = !fin_ff && !((cnt_ff == gtr_pkg::CHUNK_BYTES) && !out_free);

      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      fin_in       = fin_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_bytes_in = out_bytes_ff;
      out_count_in = out_count_ff;
      out_last_in  = out_last_ff;

      if (fin_ff && out_free) begin
         out_valid_in = 1'b1;
         out_bytes_in = acc_ff;
         out_count_in = cnt_ff;
         out_last_in  = 1'b1;
         acc_in       = '0;
         cnt_in       = '0;
         fin_in       = 1'b0;
      end else if (cmd.push) begin
         if (cnt_ff == gtr_pkg::CHUNK_BYTES) begin
            out_valid_in = 1'b1;
            out_bytes_in = acc_ff;
            out_count_in = cnt_ff;
            out_last_in  = 1'b0;
            acc_in       = '0;
            acc_in[0]    = push_byte;
            cnt_in       = 4'd1;
         end else begin
            acc_in[cnt_ff[2:0]] = push_byte;
            cnt_in              = cnt_ff + 4'd1;
         end
         fin_in = cmd.last_beat;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign out_bytes  = out_bytes_ff;
   assign out_count  = out_count_ff;
   assign out_last   = out_last_ff;

`ifndef SYNTHESIS
   a_push_when_ready: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> pack_ready)
      else $error("byte pushed into a blocked packer");

   a_mem_push_in_word: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && (cmd.src == gtr_pkg::SRC_MEM)) |-> (remain_ff != 8'd0))
      else $error("held byte pushed past the end of the word");

   a_out_count: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_count_ff != 4'd0) && (out_count_ff <= gtr_pkg::CHUNK_BYTES)))
      else $error("result beat with bad byte count");

   a_fin_nonempty: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> (cnt_ff != 4'd0))
      else $error("run closed on an empty chunk");

   a_store_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && ((cmd.act == gtr_pkg::ACT_HOLD) || (cmd.act == gtr_pkg::ACT_BREAK)))
      |-> (held_ff < MAXW8))
      else $error("word store written beyond its depth");
`endif

endmodule

`default_nettype wire
